### hw/rtl/wrsi_pkg.sv
// Shared types and constants for the Wilder RSI stream block.
`default_nettype none

package wrsi_pkg;

  localparam int PERIOD_W = 8;
  localparam int MUL_IDX_W = $clog2(PERIOD_W);
  localparam int INDEX_W = 9;
  localparam int RSI_W = 23;
  localparam int RSI_FRAC = 16;
  localparam int RSI_INT_W = RSI_W - RSI_FRAC;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd14;
  localparam logic [INDEX_W-1:0] INDEX_CAP = 9'd256;
  localparam logic [RSI_W-1:0] RSI_FULL_SCALE = 23'd6553600;

  typedef struct packed {
    logic clear;
    logic accum;
    logic load_div;
    logic load_mac;
    logic mac_step;
    logic mac_bit;
    logic div_step;
    logic commit;
  } lane_ctl_t;

endpackage

`default_nettype wire

### hw/rtl/wrsi_in_if.sv
// Price sample channel.
`default_nettype none

interface wrsi_in_if #(
  parameter int PRICE_WIDTH = 32
);
  logic                   valid;
  logic                   ready;
  logic [PRICE_WIDTH-1:0] price;
  logic                   series_start;

  modport source (output valid, price, series_start, input ready);
  modport sink (input valid, price, series_start, output ready);
endinterface

`default_nettype wire

### hw/rtl/wrsi_out_if.sv
// RSI result channel.
`default_nettype none

interface wrsi_out_if import wrsi_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RSI_W-1:0] rsi_value;
  logic             rsi_valid;

  modport source (output valid, rsi_value, rsi_valid, input ready);
  modport sink (input valid, rsi_value, rsi_valid, output ready);
endinterface

`default_nettype wire

### hw/rtl/wilder_rsi_stream.sv
// Top level of the streaming RSI block with Wilder smoothing.
//
//  channel      dir   payload                          beat when
//  samples      in    price, series_start              samples.valid && samples.ready
//  results      out   rsi_value, rsi_valid             results.valid && results.ready
//  cfg_wr_*     in    smoothing period (8 bits)        cfg_wr_en
//
// A series start or a warm-up sample goes straight from ST_IDLE to ST_FIN. The sample
// that completes the initial average passes ST_LOAD, the bit-serial divide by the
// period (ST_DIV), ST_COMMIT, ST_RSI_A, ST_RSI_B and the 23-step RSI divide (ST_RSI_DIV);
// a smoothing sample takes the bit-serial multiply (ST_MAC) in place of ST_LOAD.
// Reset is synchronous and needs no clearing pass; the output register lets the next
// sample in while a result waits.
`default_nettype none

module wilder_rsi_stream import wrsi_pkg::*; #(
  parameter int PRICE_WIDTH = 32,
  parameter int AVERAGE_FRAC_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  wrsi_in_if.sink                  samples,
  wrsi_out_if.source               results,
  input  wire logic                cfg_wr_en,
  input  wire logic [PERIOD_W-1:0] cfg_wr_data
);

  localparam int AW = PRICE_WIDTH + AVERAGE_FRAC_BITS + PERIOD_W;
  localparam int VW = AW + PERIOD_W;
  localparam int NW = AW + 7;
  localparam int CW = $clog2(VW);

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD, ST_MAC, ST_DIV, ST_COMMIT, ST_RSI_A, ST_RSI_B, ST_RSI_DIV, ST_FIN
  } state_t;

  state_t                 state;
  logic [PERIOD_W-1:0]    period;
  logic [PRICE_WIDTH-1:0] prev;
  logic [INDEX_W-1:0]     idx;
  logic [CW-1:0]          cnt;
  logic                   res_live;

  logic [NW-1:0]          t_sum;
  logic [AW:0]            den;
  logic                   lzero;
  logic [AW:0]            r;
  logic [RSI_W-1:0]       nl;
  logic [RSI_W-1:0]       q;

  logic [PERIOD_W-1:0]    p_eff;
  logic [PERIOD_W-1:0]    p_less;
  logic [INDEX_W-1:0]     idx_next;
  logic                   accept;
  logic                   rising;
  logic [PRICE_WIDTH-1:0] diff;
  logic [AW-1:0]          up_x;
  logic [AW-1:0]          down_x;
  logic [AW-1:0]          gain;
  logic [AW-1:0]          loss;
  lane_ctl_t              gain_ctl;
  lane_ctl_t              loss_ctl;
  logic [NW-1:0]          n_full;
  logic [AW+1:0]          rt;
  logic                   ge;

  assign p_eff = (period == '0) ? PERIOD_W'(1) : period;
  assign p_less = p_eff - PERIOD_W'(1);
  assign idx_next = (idx == INDEX_CAP) ? idx : idx + INDEX_W'(1);
  assign samples.ready = state == ST_IDLE;
  assign accept = samples.valid && samples.ready;

  assign rising = samples.price > prev;
  assign diff = rising ? samples.price - prev : prev - samples.price;
  assign up_x = rising ? AW'(diff) << AVERAGE_FRAC_BITS : '0;
  assign down_x = rising ? '0 : AW'(diff) << AVERAGE_FRAC_BITS;

  always_comb begin
    gain_ctl = '0;
    gain_ctl.clear = accept && samples.series_start;
    gain_ctl.accum = accept && !samples.series_start && idx_next <= {1'b0, p_eff};
    gain_ctl.load_mac = accept && !samples.series_start && idx_next > {1'b0, p_eff};
    gain_ctl.load_div = state == ST_LOAD;
    gain_ctl.mac_step = state == ST_MAC;
    gain_ctl.mac_bit = p_less[cnt[MUL_IDX_W-1:0]];
    gain_ctl.div_step = state == ST_DIV;
    gain_ctl.commit = state == ST_COMMIT;
    loss_ctl = gain_ctl;
  end

  wrsi_lane #(.AVG_W(AW)) u_gain (
    .clk     (clk),
    .rst     (rst),
    .ctl     (gain_ctl),
    .x       (up_x),
    .divisor (p_eff),
    .avg     (gain)
  );

  wrsi_lane #(.AVG_W(AW)) u_loss (
    .clk     (clk),
    .rst     (rst),
    .ctl     (loss_ctl),
    .x       (down_x),
    .divisor (p_eff),
    .avg     (loss)
  );

  // The numerator is gain * 100 * 2^16; gain * 100 is gain * 64 + gain * 32 + gain * 4.
  assign n_full = t_sum + (NW'(gain) << 2);
  assign rt = {r, nl[RSI_W-1]};
  assign ge = rt >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      period <= PERIOD_RESET;
      prev <= '0;
      idx <= '0;
      cnt <= '0;
      res_live <= 1'b0;
      results.valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        period <= cfg_wr_data;
      end
      if (state == ST_FIN && (!results.valid || results.ready)) begin
        results.valid <= 1'b1;
        results.rsi_valid <= res_live;
        results.rsi_value <= !res_live ? '0 : (lzero ? RSI_FULL_SCALE : q);
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          cnt <= '0;
          if (accept) begin
            prev <= samples.price;
            if (samples.series_start) begin
              idx <= '0;
              res_live <= 1'b0;
              state <= ST_FIN;
            end else begin
              idx <= idx_next;
              res_live <= idx_next >= {1'b0, p_eff};
              if (idx_next < {1'b0, p_eff}) begin
                state <= ST_FIN;
              end else if (idx_next == {1'b0, p_eff}) begin
                state <= ST_LOAD;
              end else begin
                state <= ST_MAC;
              end
            end
          end
        end
        ST_LOAD: begin
          state <= ST_DIV;
        end
        ST_MAC: begin
          if (cnt == CW'(PERIOD_W - 1)) begin
            cnt <= '0;
            state <= ST_DIV;
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        ST_DIV: begin
          if (cnt == CW'(VW - 1)) begin
            cnt <= '0;
            state <= ST_COMMIT;
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        ST_COMMIT: begin
          state <= ST_RSI_A;
        end
        ST_RSI_A: begin
          t_sum <= (NW'(gain) << 6) + (NW'(gain) << 5);
          den <= (AW + 1)'(gain) + (AW + 1)'(loss);
          lzero <= loss == '0;
          state <= ST_RSI_B;
        end
        ST_RSI_B: begin
          r <= (AW + 1)'(n_full >> RSI_INT_W);
          nl <= RSI_W'(n_full[RSI_INT_W-1:0]) << RSI_FRAC;
          state <= ST_RSI_DIV;
        end
        ST_RSI_DIV: begin
          r <= ge ? (AW + 1)'(rt - {1'b0, den}) : rt[AW:0];
          nl <= nl << 1;
          q <= {q[RSI_W-2:0], ge};
          if (cnt == CW'(RSI_W - 1)) begin
            cnt <= '0;
            state <= ST_FIN;
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        ST_FIN: begin
          if (!results.valid || results.ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_warmup_zero: assert property (@(posedge clk) disable iff (rst)
    results.valid && !results.rsi_valid |-> results.rsi_value == '0)
    else $error("warm-up result carries a nonzero RSI");

  a_rsi_range: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> results.rsi_value <= RSI_FULL_SCALE)
    else $error("RSI above full scale");

  a_index_cap: assert property (@(posedge clk) disable iff (rst)
    idx <= INDEX_CAP)
    else $error("sample index beyond its cap");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    samples.valid && samples.ready |=> !samples.ready)
    else $error("new sample taken while one is in progress");

endmodule

`default_nettype wire

### hw/rtl/wrsi_lane.sv
// One average lane: accumulator, bit-serial multiply and bit-serial divide by the period.
`default_nettype none

module wrsi_lane import wrsi_pkg::*; #(
  parameter int AVG_W = 56
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire lane_ctl_t           ctl,
  input  wire logic [AVG_W-1:0]    x,
  input  wire logic [PERIOD_W-1:0] divisor,
  output      logic [AVG_W-1:0]    avg
);

  localparam int VW = AVG_W + PERIOD_W;

  logic [VW-1:0]       v;
  logic [VW-1:0]       m;
  logic [PERIOD_W-1:0] rem;
  logic [PERIOD_W:0]   rt;
  logic                ge;

  assign rt = {rem, v[VW-1]};
  assign ge = rt >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      avg <= '0;
    end else if (ctl.clear) begin
      avg <= '0;
    end else if (ctl.accum) begin
      avg <= avg + x;
    end else if (ctl.commit) begin
      avg <= v[AVG_W-1:0];
    end
  end

  // The quotient bits enter at the bottom of v as the dividend leaves at the top.
  always_ff @(posedge clk) begin
    if (ctl.load_div) begin
      v <= VW'(avg);
      rem <= '0;
    end else if (ctl.load_mac) begin
      v <= VW'(x);
      m <= VW'(avg);
      rem <= '0;
    end else if (ctl.mac_step) begin
      if (ctl.mac_bit) begin
        v <= v + m;
      end
      m <= m << 1;
    end else if (ctl.div_step) begin
      rem <= ge ? PERIOD_W'(rt - {1'b0, divisor}) : rt[PERIOD_W-1:0];
      v <= {v[VW-2:0], ge};
    end
  end

endmodule

`default_nettype wire
